// ===== hdl/swpd_pkg.sv =====
package swpd_pkg;

	localparam int MAX_WINDOW  = 32;
	localparam int SAMPLE_BITS = 24;

	localparam int FIELD_BITS = 24;
	localparam int FILL_BITS  = 6;
	localparam int IN_BYTES   = (3 * FIELD_BITS + 7) / 8;
	localparam int OUT_BYTES  = (4 * FIELD_BITS + FILL_BITS + 7) / 8;
	localparam int IN_TDATA_W  = IN_BYTES * 8;
	localparam int OUT_TDATA_W = OUT_BYTES * 8;

	localparam logic [FILL_BITS-1:0] WINDOW_RESET = FILL_BITS'(8);

	typedef struct packed {
		logic [FILL_BITS-1:0]  window_fill;
		logic [FIELD_BITS-1:0] z_deviation;
		logic [FIELD_BITS-1:0] y_deviation;
		logic [FIELD_BITS-1:0] x_deviation;
		logic [FIELD_BITS-1:0] max_deviation;
	} result_t;

endpackage

// ===== hdl/swpd_ram.sv =====
module swpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end
endmodule

// ===== hdl/swpd_front.sv =====
module swpd_front #(
	parameter int SAMPLE_BITS = swpd_pkg::SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [swpd_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic                          q_valid,
	output logic [3*SAMPLE_BITS-1:0]      q_sample,
	input  logic                          q_pop
);
	import swpd_pkg::*;

	localparam int SW = 3 * SAMPLE_BITS;

	logic [SW-1:0] slot_q [2];
	logic          rd_q, wr_q;
	logic [1:0]    count_q;
	logic          push;
	logic [SW-1:0] packed_in;

	// keep the low sample bits of each 24-bit field
	assign packed_in = {s_tdata[2*FIELD_BITS +: SAMPLE_BITS],
	                    s_tdata[FIELD_BITS +: SAMPLE_BITS],
	                    s_tdata[0 +: SAMPLE_BITS]};

	assign s_tready = (count_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != 2'd0);
	assign q_sample = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= 1'b0;
			wr_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (q_pop)
				rd_q <= !rd_q;
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= packed_in;
	end
endmodule

// ===== hdl/swpd_back.sv =====
module swpd_back #(
	parameter int MAX_WINDOW  = swpd_pkg::MAX_WINDOW,
	parameter int SAMPLE_BITS = swpd_pkg::SAMPLE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [swpd_pkg::FILL_BITS-1:0] cfg_wdata,
	input  logic                         q_valid,
	input  logic [3*SAMPLE_BITS-1:0]     q_sample,
	output logic                         q_pop,
	output logic                         res_valid,
	input  logic                         res_ready,
	output swpd_pkg::result_t            res
);
	import swpd_pkg::*;

	localparam int SB     = SAMPLE_BITS;
	localparam int FW     = FILL_BITS;
	localparam int PW     = $clog2(MAX_WINDOW);
	localparam int SUM_W  = SB + FW;
	localparam int SQS_W  = 2 * SB + FW;
	localparam int NUM_W  = 2 * SB + 2 * FW;
	localparam int RT_W   = NUM_W / 2;
	localparam int DW     = 2 * FW;
	localparam int CW     = $clog2(NUM_W + 1);
	localparam int MAG_W  = SUM_W - 1;

	typedef enum logic [3:0] {
		IDLE, RD, SQO, SQN, UPD, MUL, SUB, DIV, SQRT, DONE
	} state_t;

	state_t              state_q;
	logic [FW-1:0]       wsize_q, fill_q, w_eff;
	logic [PW-1:0]       oldest_q, slot_q;
	logic                full_q;
	logic [1:0]          axis_q;
	logic [3*SB-1:0]     new_q, old_q;
	logic signed [SUM_W-1:0] sum_q [3];
	logic [SQS_W-1:0]    sqs_q [3];
	logic [2*SB-1:0]     prod_q;
	logic [NUM_W-1:0]    num_q, sq_q, quo_q;
	logic [DW-1:0]       dsor_q, rem_q;
	logic [RT_W+1:0]     srem_q;
	logic [RT_W-1:0]     root_q;
	logic [CW-1:0]       cnt_q;
	logic [FIELD_BITS-1:0] dev_q [3];
	logic [FW:0]         slot_sum;
	logic [3*SB-1:0]     rdata;
	logic [SB-1:0]       old_ax, new_ax, old_mag, new_mag;
	logic signed [SUM_W-1:0] sum_cur;
	logic [MAG_W-1:0]    sum_mag;
	logic [FW+SQS_W-1:0] num_full;
	logic [DW:0]         div_r2;
	logic [RT_W+1:0]     sq_rem2, sq_trial;
	logic [FIELD_BITS-1:0] best_xy;

	always_comb begin
		if (wsize_q == '0)
			w_eff = FW'(1);
		else if (32'(wsize_q) > MAX_WINDOW)
			w_eff = FW'(MAX_WINDOW);
		else
			w_eff = wsize_q;
	end

	// oldest is below the window and fill at most the window, one subtract wraps the ring
	always_comb begin
		slot_sum = {1'b0, FW'(oldest_q)} + {1'b0, fill_q};
		if (slot_sum >= {1'b0, w_eff})
			slot_sum = slot_sum - {1'b0, w_eff};
	end

	swpd_ram #(.WIDTH(3 * SB), .DEPTH(MAX_WINDOW)) u_hist (
		.clk    (clk),
		.we     (state_q == RD),
		.waddr  (slot_q),
		.wdata  (new_q),
		.raddr  ((fill_q < w_eff) ? PW'(slot_sum) : oldest_q),
		.rdata_q(rdata)
	);

	assign old_ax  = old_q[axis_q*SB +: SB];
	assign new_ax  = new_q[axis_q*SB +: SB];
	assign old_mag = old_ax[SB-1] ? SB'(-old_ax) : old_ax;
	assign new_mag = new_ax[SB-1] ? SB'(-new_ax) : new_ax;
	assign sum_cur = sum_q[axis_q];
	assign sum_mag = sum_cur[SUM_W-1] ? MAG_W'(-sum_cur) : MAG_W'(sum_cur);
	assign num_full = fill_q * sqs_q[axis_q];
	assign div_r2   = {rem_q, quo_q[NUM_W-1]};
	assign sq_rem2  = {srem_q[RT_W-1:0], quo_q[NUM_W-1 -: 2]};
	assign sq_trial = {root_q, 2'b01};
	assign best_xy  = (dev_q[1] > dev_q[0]) ? dev_q[1] : dev_q[0];

	assign q_pop     = (state_q == IDLE) && q_valid;
	assign res_valid = (state_q == DONE);
	assign res.max_deviation = (dev_q[2] > best_xy) ? dev_q[2] : best_xy;
	assign res.x_deviation   = dev_q[0];
	assign res.y_deviation   = dev_q[1];
	assign res.z_deviation   = dev_q[2];
	assign res.window_fill   = fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			wsize_q  <= WINDOW_RESET;
			fill_q   <= '0;
			oldest_q <= '0;
			full_q   <= 1'b0;
			axis_q   <= '0;
			cnt_q    <= '0;
			for (int a = 0; a < 3; a++) begin
				sum_q[a] <= '0;
				sqs_q[a] <= '0;
			end
		end else begin
			if (cfg_we) begin
				wsize_q  <= cfg_wdata;
				fill_q   <= '0;
				oldest_q <= '0;
				for (int a = 0; a < 3; a++) begin
					sum_q[a] <= '0;
					sqs_q[a] <= '0;
				end
			end
			case (state_q)
				IDLE: begin
					if (q_valid) begin
						new_q <= q_sample;
						if (fill_q < w_eff) begin
							slot_q <= PW'(slot_sum);
							fill_q <= fill_q + FW'(1);
							full_q <= 1'b0;
						end else begin
							slot_q   <= oldest_q;
							full_q   <= 1'b1;
							oldest_q <= ({1'b0, FW'(oldest_q)} + 1'b1 == {1'b0, w_eff})
							            ? '0 : oldest_q + PW'(1);
						end
						state_q <= RD;
					end
				end
				RD: begin
					old_q   <= rdata;
					axis_q  <= '0;
					state_q <= SQO;
				end
				SQO: begin
					prod_q  <= full_q ? old_mag * old_mag : '0;
					state_q <= SQN;
				end
				SQN: begin
					sqs_q[axis_q] <= sqs_q[axis_q] - SQS_W'(prod_q);
					if (full_q)
						sum_q[axis_q] <= sum_q[axis_q] - SUM_W'(signed'(old_ax));
					prod_q  <= new_mag * new_mag;
					state_q <= UPD;
				end
				UPD: begin
					sqs_q[axis_q] <= sqs_q[axis_q] + SQS_W'(prod_q);
					sum_q[axis_q] <= sum_q[axis_q] + SUM_W'(signed'(new_ax));
					state_q <= MUL;
				end
				MUL: begin
					num_q   <= NUM_W'(num_full);
					sq_q    <= NUM_W'(sum_mag * sum_mag);
					dsor_q  <= fill_q * fill_q;
					state_q <= SUB;
				end
				SUB: begin
					quo_q   <= (num_q >= sq_q) ? num_q - sq_q : '0;
					rem_q   <= '0;
					cnt_q   <= CW'(NUM_W);
					state_q <= DIV;
				end
				DIV: begin
					if (div_r2 >= {1'b0, dsor_q}) begin
						rem_q <= DW'(div_r2 - {1'b0, dsor_q});
						quo_q <= {quo_q[NUM_W-2:0], 1'b1};
					end else begin
						rem_q <= DW'(div_r2);
						quo_q <= {quo_q[NUM_W-2:0], 1'b0};
					end
					if (cnt_q == CW'(1)) begin
						cnt_q   <= CW'(RT_W);
						srem_q  <= '0;
						root_q  <= '0;
						state_q <= SQRT;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				SQRT: begin
					// one result bit per step, two radicand bits consumed
					quo_q <= {quo_q[NUM_W-3:0], 2'b00};
					if (sq_rem2 >= sq_trial) begin
						srem_q <= sq_rem2 - sq_trial;
						root_q <= {root_q[RT_W-2:0], 1'b1};
					end else begin
						srem_q <= sq_rem2;
						root_q <= {root_q[RT_W-2:0], 1'b0};
					end
					if (cnt_q == CW'(1)) begin
						dev_q[axis_q] <= FIELD_BITS'(sq_rem2 >= sq_trial
						                 ? {root_q[RT_W-2:0], 1'b1}
						                 : {root_q[RT_W-2:0], 1'b0});
						if (axis_q == 2'd2) begin
							state_q <= DONE;
						end else begin
							axis_q  <= axis_q + 2'd1;
							state_q <= SQO;
						end
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				DONE: begin
					if (res_ready)
						state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= MAX_WINDOW)
		else $error("fill count beyond window store");

	a_ptr_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) || ({1'b0, FW'(oldest_q)} < {1'b0, w_eff}))
		else $error("oldest pointer outside window");

	a_result_has_fill: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (fill_q != '0))
		else $error("result with empty window");
endmodule

// ===== hdl/sliding_window_pose_deviation_unit.sv =====
// Sliding-window pose deviation: each x/y/z Q12.12 sample updates a ring of the
// last window_size samples with running sums and sums of squares, and returns the
// population standard deviation per axis plus their maximum and the window fill.
// A two-entry input queue takes samples while the arithmetic unit works. Each
// sample occupies the unit through the bit-serial divide and square root run per
// axis, and the next sample is taken only once the result has been accepted.
// Writing window_size empties the window; the history memory is not cleared.
module sliding_window_pose_deviation_unit #(
	parameter int MAX_WINDOW  = swpd_pkg::MAX_WINDOW,
	parameter int SAMPLE_BITS = swpd_pkg::SAMPLE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [swpd_pkg::FILL_BITS-1:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// x_position, y_position, z_position
	input  logic [swpd_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// max_deviation, x_deviation, y_deviation, z_deviation, window_fill
	output logic [swpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import swpd_pkg::*;

	logic                     q_valid, q_pop, res_valid, res_ready;
	logic [3*SAMPLE_BITS-1:0] q_sample;
	result_t                  res, out_q;
	logic                     out_valid_q;

	assign cfg_ready = 1'b1;

	swpd_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_axis_tvalid),
		.s_tready(s_axis_tready),
		.s_tdata (s_axis_tdata),
		.q_valid (q_valid),
		.q_sample(q_sample),
		.q_pop   (q_pop)
	);

	swpd_back #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid),
		.cfg_wdata(cfg_data),
		.q_valid  (q_valid),
		.q_sample (q_sample),
		.q_pop    (q_pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid)
			out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_q);
endmodule

// ===== bench/sliding_window_pose_deviation_checker.sv =====
module sliding_window_pose_deviation_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [swpd_pkg::FILL_BITS-1:0] cfg_data,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [swpd_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [swpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output int   mismatches,
	output int   pending
);
	import swpd_pkg::*;

	logic signed [63:0] hist [3][MAX_WINDOW];
	logic signed [63:0] sums [3];
	logic [63:0] sq_sums [3];
	int oldest;
	int fill;
	logic [5:0] win_reg;
	result_t deviations_due [$];

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v = v - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic logic [63:0] axis_dev(input int a, input logic [63:0] n);
		logic [63:0] s;
		logic [63:0] num;
		logic [63:0] sq;
		logic [63:0] diff;
		s = sums[a] < 0 ? -sums[a] : sums[a];
		num = n * sq_sums[a];
		sq = s * s;
		diff = num >= sq ? num - sq : 0;
		if (n == 0)
			return 0;
		return int_sqrt(diff / (n * n));
	endfunction

	task automatic take_sample(input logic [IN_TDATA_W-1:0] d);
		logic signed [63:0] smp [3];
		logic signed [63:0] old;
		logic [63:0] dev [3];
		logic [63:0] best;
		int w;
		int slot;
		result_t r;
		w = win_reg == 0 ? 1 : (win_reg > MAX_WINDOW ? MAX_WINDOW : win_reg);
		for (int a = 0; a < 3; a++)
			smp[a] = 64'(signed'(d[a*24 +: 24]));
		if (fill < w) begin
			slot = (oldest + fill) % w;
			fill++;
		end else begin
			slot = oldest % w;
			for (int a = 0; a < 3; a++) begin
				old = hist[a][slot];
				sums[a] -= old;
				sq_sums[a] -= old * old;
			end
			oldest = (slot + 1) % w;
		end
		for (int a = 0; a < 3; a++) begin
			hist[a][slot] = smp[a];
			sums[a] += smp[a];
			sq_sums[a] += smp[a] * smp[a];
		end
		for (int a = 0; a < 3; a++)
			dev[a] = axis_dev(a, 64'(fill));
		best = dev[0];
		if (dev[1] > best) best = dev[1];
		if (dev[2] > best) best = dev[2];
		r.max_deviation = best[23:0];
		r.x_deviation = dev[0][23:0];
		r.y_deviation = dev[1][23:0];
		r.z_deviation = dev[2][23:0];
		r.window_fill = 6'(fill);
		deviations_due = {deviations_due, r};
	endtask

	task automatic empty_window();
		oldest = 0;
		fill = 0;
		for (int a = 0; a < 3; a++) begin
			sums[a] = 0;
			sq_sums[a] = 0;
		end
	endtask

	initial begin
		mismatches = 0;
		pending = 0;
		win_reg = WINDOW_RESET;
		empty_window();
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				win_reg = cfg_data;
				empty_window();
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
				if (deviations_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", got);
				end else begin
					want = deviations_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected max %h x %h y %h z %h fill %0d,",
								" got max %h x %h y %h z %h fill %0d"},
								want.max_deviation, want.x_deviation, want.y_deviation,
								want.z_deviation, want.window_fill, got.max_deviation,
								got.x_deviation, got.y_deviation, got.z_deviation,
								got.window_fill);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				take_sample(s_axis_tdata);
			pending = deviations_due.size();
		end
	end
endmodule

// ===== bench/sliding_window_pose_deviation_unit_test.sv =====
module sliding_window_pose_deviation_unit_test;
	import swpd_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [FILL_BITS-1:0] cfg_data = '0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	int mismatches;
	int pending;
	bit calm = 0;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	sliding_window_pose_deviation_unit uut (.*);

	sliding_window_pose_deviation_checker chk (.*);

	// result side stalls
	always @(posedge clk)
		m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 29);

	function automatic logic [23:0] rand_coord(input int mode);
		case (mode)
			0: return 24'h7fffff;
			1: return 24'h800000;
			2: return 24'($urandom_range(0, 255)) - 24'd128;
			default: return 24'($urandom);
		endcase
	endfunction

	// valid stays high after a transfer until the next idle cycle or drain
	task automatic send_pose(input logic [23:0] x, input logic [23:0] y, input logic [23:0] z);
		while (!calm && $urandom_range(0, 99) < 29) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {z, y, x};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_window(input logic [5:0] w);
		drain();
		cfg_valid <= 1;
		cfg_data <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
	endtask

	initial begin
		logic [5:0] sizes [6] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd5};
		int m;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// reset window of eight, extremes then single sample case
		send_pose(24'h7fffff, 24'h800000, 24'h000000);
		send_pose(24'h800000, 24'h7fffff, 24'hffffff);
		repeat (8) send_pose(24'h7fffff, 24'h800000, 24'h7fffff);
		send_pose(24'h800000, 24'h800000, 24'h800000);
		write_window(6'd1);
		send_pose(24'h7fffff, 24'h800000, 24'h123456);
		send_pose(24'h800000, 24'h7fffff, 24'h000001);
		write_window(6'd32);
		for (int i = 0; i < 34; i++)
			send_pose(i[0] ? 24'h7fffff : 24'h800000, 24'($urandom), 24'h000000);
		write_window(6'd0);
		send_pose(24'h7fffff, 24'h7fffff, 24'h7fffff);
		send_pose(24'h800000, 24'h000000, 24'hffffff);
		write_window(6'd63);
		for (int i = 0; i < 36; i++)
			send_pose(24'($urandom), 24'($urandom), 24'($urandom));
		for (int p = 0; p < 12; p++) begin
			write_window(p < 6 ? sizes[p] : 6'($urandom_range(1, 40)));
			calm = (p == 4);
			m = $urandom_range(0, 3);
			for (int i = 0; i < 60; i++) begin
				if (p == 7 && i == 30)
					drain();
				send_pose(rand_coord($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : m),
					rand_coord(m), rand_coord($urandom_range(0, 3)));
			end
			calm = 0;
		end
		drain();
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#50000000;
		$display("Some tests failed");
		$finish;
	end
endmodule
